// File: rtl/max_length_sequence_generator_unit_macros.svh
// assertion helpers for the sequence generator
`ifndef MAX_LENGTH_SEQUENCE_GENERATOR_UNIT_MACROS_SVH
`define MAX_LENGTH_SEQUENCE_GENERATOR_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define MLSG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define MLSG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/mlsg_pkg.sv
package mlsg_pkg;

  localparam int MaxLength = 32;
  localparam int LenWidth  = 6;
  localparam logic [LenWidth-1:0] LenMin   = 6'd2;
  localparam logic [LenWidth-1:0] LenMax   = 6'd32;
  localparam logic [LenWidth-1:0] LenReset = 6'd2;

  localparam logic FuncLoad = 1'b0;
  localparam logic FuncStep = 1'b1;

  // per-cycle commands to the cell row
  typedef struct packed {
    logic init;   // return to the single-one start pattern
    logic load;   // take the seed
    logic shift;  // advance one step
  } mlsg_ctrl_t;

  function automatic logic [LenWidth-1:0] clamp_len(input logic [LenWidth-1:0] v);
    logic [LenWidth-1:0] r;
    r = v;
    if (v < LenMin) r = LenMin;
    if (v > LenMax) r = LenMax;
    return r;
  endfunction

  function automatic logic [MaxLength-1:0] len_mask(input logic [LenWidth-1:0] n);
    logic [MaxLength-1:0] r;
    if (n >= LenMax) r = '1;
    else r = (MaxLength'(1) << n) - MaxLength'(1);
    return r;
  endfunction

  // one-hot of the top cell, bit n-1
  function automatic logic [MaxLength-1:0] top_onehot(input logic [LenWidth-1:0] n);
    logic [MaxLength-1:0] m;
    m = len_mask(n);
    return m ^ (m >> 1);
  endfunction

  // feedback taps including the oldest bit at position 0
  function automatic logic [MaxLength-1:0] tap_mask(input logic [LenWidth-1:0] n);
    logic [4:0] d0;
    logic [4:0] d1;
    logic [4:0] d2;
    logic       three;
    logic [MaxLength-1:0] r;
    d0 = 5'd1;
    d1 = 5'd0;
    d2 = 5'd0;
    three = 1'b0;
    case (n)
      6'd2:  d0 = 5'd1;
      6'd3:  d0 = 5'd2;
      6'd4:  d0 = 5'd3;
      6'd5:  d0 = 5'd3;
      6'd6:  d0 = 5'd5;
      6'd7:  d0 = 5'd6;
      6'd8:  begin d0 = 5'd7;  d1 = 5'd6;  d2 = 5'd1;  three = 1'b1; end
      6'd9:  d0 = 5'd5;
      6'd10: d0 = 5'd7;
      6'd11: d0 = 5'd9;
      6'd12: begin d0 = 5'd11; d1 = 5'd10; d2 = 5'd4;  three = 1'b1; end
      6'd13: begin d0 = 5'd12; d1 = 5'd11; d2 = 5'd8;  three = 1'b1; end
      6'd14: begin d0 = 5'd13; d1 = 5'd12; d2 = 5'd2;  three = 1'b1; end
      6'd15: d0 = 5'd14;
      6'd16: begin d0 = 5'd15; d1 = 5'd13; d2 = 5'd4;  three = 1'b1; end
      6'd17: d0 = 5'd14;
      6'd18: d0 = 5'd11;
      6'd19: begin d0 = 5'd18; d1 = 5'd17; d2 = 5'd14; three = 1'b1; end
      6'd20: d0 = 5'd17;
      6'd21: d0 = 5'd19;
      6'd22: d0 = 5'd21;
      6'd23: d0 = 5'd18;
      6'd24: begin d0 = 5'd23; d1 = 5'd22; d2 = 5'd17; three = 1'b1; end
      6'd25: d0 = 5'd22;
      6'd26: begin d0 = 5'd25; d1 = 5'd24; d2 = 5'd20; three = 1'b1; end
      6'd27: begin d0 = 5'd26; d1 = 5'd25; d2 = 5'd22; three = 1'b1; end
      6'd28: d0 = 5'd25;
      6'd29: d0 = 5'd27;
      6'd30: begin d0 = 5'd29; d1 = 5'd28; d2 = 5'd7;  three = 1'b1; end
      6'd31: d0 = 5'd28;
      6'd32: begin d0 = 5'd31; d1 = 5'd30; d2 = 5'd10; three = 1'b1; end
      default: d0 = 5'd1;
    endcase
    r = MaxLength'(1) | (MaxLength'(1) << d0);
    if (three) r = r | (MaxLength'(1) << d1) | (MaxLength'(1) << d2);
    return r;
  endfunction

endpackage

// File: rtl/mlsg_cell.sv
module mlsg_cell (
  input  logic               clk,
  input  logic               rst,
  input  mlsg_pkg::mlsg_ctrl_t ctrl,
  input  logic               init_bit,   // start pattern value of this cell
  input  logic               seed_bit,
  input  logic               active,     // cell lies inside the current length
  input  logic               top,        // cell is bit length-1
  input  logic               right_bit,  // neighbor one place up
  input  logic               fb,
  output logic               q
);
  import mlsg_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= init_bit;
    end else if (ctrl.init) begin
      q <= init_bit;
    end else if (ctrl.load) begin
      q <= seed_bit & active;
    end else if (ctrl.shift) begin
      q <= top ? fb : right_bit;
    end
  end

endmodule

// File: rtl/mlsg_chain.sv
module mlsg_chain (
  input  logic                              clk,
  input  logic                              rst,
  input  mlsg_pkg::mlsg_ctrl_t              ctrl,
  input  logic [mlsg_pkg::MaxLength-1:0]    seed,
  input  logic [mlsg_pkg::MaxLength-1:0]    active_mask,
  input  logic [mlsg_pkg::MaxLength-1:0]    top_sel,
  input  logic [mlsg_pkg::MaxLength-1:0]    tap_sel,
  output logic [mlsg_pkg::MaxLength-1:0]    state
);
  import mlsg_pkg::*;

  logic [MaxLength:1] right;
  logic               fb;

  // bits above the length are zero, so the top cell of the row shifts in zero
  assign right = {1'b0, state[MaxLength-1:1]};
  assign fb    = ^(state & tap_sel);

  for (genvar i = 0; i < MaxLength; i++) begin : g_cell
    mlsg_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .init_bit  (i == 0),
      .seed_bit  (seed[i]),
      .active    (active_mask[i]),
      .top       (top_sel[i]),
      .right_bit (right[i+1]),
      .fb        (fb),
      .q         (state[i])
    );
  end

endmodule

// File: rtl/max_length_sequence_generator_unit.sv
// Maximum length sequence generator: a Fibonacci shift register of 2 to 32
// cells whose length is set by cfg_wdata (clamped to 2..32; a write also
// restarts the register at 1 and the period position at 0). A request with
// tuser = 0 loads the low length bits of tdata as seed and is answered with
// tuser = 1 if those bits are all zero, in which case nothing changes. A
// request with tuser = 1 emits the oldest bit, feeds back the XOR of the
// tapped cells into the top cell and reports the bit's position in the
// period, with tlast on the final bit. Every request gives exactly one
// response, registered in the cycle after; while downstream keeps up, a
// new request is taken every cycle, as cells and position counter update
// on acceptance and the response register frees once downstream takes it.
`include "max_length_sequence_generator_unit_macros.svh"

module max_length_sequence_generator_unit (
  input  logic                          clk,
  input  logic                          rst,
  // length register write
  input  logic                          cfg_we,
  input  logic [mlsg_pkg::LenWidth-1:0] cfg_wdata,
  // request side
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,   // seed[31:0]
  input  logic                          s_axis_tuser,   // func
  // response side
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [39:0]                   m_axis_tdata,   // out_bit, position[32:1], zeros
  output logic                          m_axis_tlast,   // period_last
  output logic                          m_axis_tuser    // seed_rejected
);
  import mlsg_pkg::*;

  // length-derived selections, recomputed on each length write
  logic [MaxLength-1:0] mask;
  logic [MaxLength-1:0] last_pos;
  logic [MaxLength-1:0] top_sel;
  logic [MaxLength-1:0] tap_sel;
  logic [LenWidth-1:0]  cfg_len;

  // period position of the next emitted bit
  logic [MaxLength-1:0] pos;
  logic [MaxLength-1:0] pos_next;

  logic [MaxLength-1:0] shift_state;
  logic [MaxLength-1:0] seed_masked;
  mlsg_ctrl_t           ctrl;

  logic s_acc;
  logic is_step;
  logic seed_zero;

  assign cfg_len = clamp_len(cfg_wdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      mask     <= len_mask(LenReset);
      last_pos <= len_mask(LenReset) - MaxLength'(1);
      top_sel  <= top_onehot(LenReset);
      tap_sel  <= tap_mask(LenReset);
    end else if (cfg_we) begin
      mask     <= len_mask(cfg_len);
      last_pos <= len_mask(cfg_len) - MaxLength'(1);
      top_sel  <= top_onehot(cfg_len);
      tap_sel  <= tap_mask(cfg_len);
    end
  end

  // response register doubles as the skid between both sides
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign is_step       = (s_axis_tuser == FuncStep);
  assign seed_masked   = s_axis_tdata & mask;
  assign seed_zero     = (seed_masked == '0);

  always_comb begin
    ctrl.init  = cfg_we;
    ctrl.load  = s_acc && !is_step && !seed_zero;
    ctrl.shift = s_acc && is_step;
  end

  mlsg_chain u_chain (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .seed        (s_axis_tdata),
    .active_mask (mask),
    .top_sel     (top_sel),
    .tap_sel     (tap_sel),
    .state       (shift_state)
  );

  // wrap after the last bit of the period
  assign pos_next = (pos >= last_pos) ? '0 : pos + MaxLength'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (cfg_we || ctrl.load) begin
      pos <= '0;
    end else if (ctrl.shift) begin
      pos <= pos_next;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_acc) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      if (is_step) begin
        m_axis_tdata <= {7'd0, pos, shift_state[0]};
        m_axis_tlast <= (pos == last_pos);
        m_axis_tuser <= 1'b0;
      end else begin
        m_axis_tdata <= '0;
        m_axis_tlast <= 1'b0;
        m_axis_tuser <= seed_zero;
      end
    end
  end

  // register never holds zero or bits beyond its length
  `MLSG_ASSERT_NOW(a_state_in_range, 1'b1,
    (shift_state != '0) && ((shift_state & ~mask) == '0), "shift state out of range")

  // a rejected seed leaves register and position alone
  `MLSG_ASSERT_NEXT(a_reject_holds, s_acc && !is_step && seed_zero && !cfg_we,
    $stable(shift_state) && $stable(pos), "rejected seed changed state")

  // stepping past the last bit of the period restarts the position
  `MLSG_ASSERT_NEXT(a_period_wrap, ctrl.shift && (pos == last_pos) && !cfg_we,
    pos == '0, "period position did not wrap")

  // an empty response register always takes a request
  `MLSG_ASSERT_NOW(a_ready_when_empty, !m_axis_tvalid, s_axis_tready,
    "request blocked with empty response register")

endmodule
